### rtl/assert_macros.svh
// Assertion helpers shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/utrbb_pkg.sv
package utrbb_pkg;

    // Store depths and the index widths that follow from them.
    localparam int TX_DEPTH = 64;
    localparam int RX_DEPTH = 64;
    localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CW    = $clog2(RX_DEPTH + 1);
    localparam int DROP_W   = 16;

    // Action codes carried by each input item.
    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_TX_DONE = 2'd1,
        ACT_RX_BYTE = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

endpackage

### rtl/utrbb_ctrl.sv
`include "assert_macros.svh"

module utrbb_ctrl
    import utrbb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   slot_free;

    // The output register can take a new result when empty or being emptied.
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = slot_free;
            end
        endcase
    end

    // State register and result-valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_NEXT(a_capture_to_exec, i_clk, i_rst_n, o_cmd.capture, r_state == ST_EXEC)
    `ASSERT_NEXT(a_commit_shows_result, i_clk, i_rst_n, o_cmd.commit, r_out_valid)

endmodule

### rtl/utrbb_dpath.sv
`include "assert_macros.svh"

module utrbb_dpath
    import utrbb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_line_ready,
    output logic        o_emit_valid,
    output logic [7:0]  o_emit_byte,
    output logic        o_read_ok,
    output logic [7:0]  o_read_value,
    output logic        o_rx_has_data,
    output logic        o_queue_full,
    output logic [15:0] o_dropped_count
);

    // Captured input item.
    t_action r_action;
    logic [7:0] r_data;
    logic       r_line_ready;

    // Stores and their registered read data.
    logic [7:0] r_tx_mem [TX_DEPTH];
    logic [7:0] r_rx_mem [RX_DEPTH];
    logic [7:0] r_tx_rd;
    logic [7:0] r_rx_rd;

    // Pointer state.
    logic [TX_AW-1:0]  r_tx_head, n_tx_head;
    logic [TX_AW-1:0]  r_tx_tail, n_tx_tail;
    logic              r_tx_full, n_tx_full;
    logic [DROP_W-1:0] r_drops, n_drops;
    logic [RX_CW-1:0]  r_rx_pos, n_rx_pos;
    logic [RX_CW-1:0]  r_rx_fill, n_rx_fill;

    // Result values before the output register.
    logic       n_emit_valid;
    logic [7:0] n_emit_byte;
    logic       n_read_ok;
    logic [7:0] n_read_value;

    logic             tx_we;
    logic             rx_we;
    logic [TX_AW-1:0] tx_head_inc;
    logic [TX_AW-1:0] tx_tail_inc;
    logic [RX_CW-1:0] rx_pos_inc;

    // Transmit ring successors wrap at the last entry; the receive position does not wrap.
    assign tx_head_inc = (r_tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_head + 1'b1;
    assign tx_tail_inc = (r_tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_tail + 1'b1;
    assign rx_pos_inc  = r_rx_pos + 1'b1;

    // Capture the item and read both stores at the current pointers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action     <= t_action'(i_action);
            r_data       <= i_data_byte;
            r_line_ready <= i_line_ready;
            r_tx_rd      <= r_tx_mem[r_tx_head];
            r_rx_rd      <= r_rx_mem[r_rx_pos[RX_AW-1:0]];
        end
    end

    // Work out the effect of the captured item.
    always_comb begin
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_full    = r_tx_full;
        n_drops      = r_drops;
        n_rx_pos     = r_rx_pos;
        n_rx_fill    = r_rx_fill;
        n_emit_valid = 1'b0;
        n_emit_byte  = 8'd0;
        n_read_ok    = 1'b0;
        n_read_value = 8'd0;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        unique case (r_action)
            ACT_SEND: begin
                if (r_tx_full) begin
                    n_drops = r_drops + 1'b1;
                end else if ((r_tx_tail != r_tx_head) || !r_line_ready) begin
                    tx_we     = 1'b1;
                    n_tx_tail = tx_tail_inc;
                    n_tx_full = (tx_tail_inc == r_tx_head);
                end else begin
                    n_emit_valid = 1'b1;
                    n_emit_byte  = r_data;
                end
            end
            ACT_TX_DONE: begin
                if ((r_tx_tail != r_tx_head) || r_tx_full) begin
                    n_emit_valid = 1'b1;
                    n_emit_byte  = r_tx_rd;
                    n_tx_full    = 1'b0;
                    n_tx_head    = tx_head_inc;
                end
            end
            ACT_RX_BYTE: begin
                if (r_rx_fill < RX_CW'(RX_DEPTH)) begin
                    rx_we     = 1'b1;
                    n_rx_fill = r_rx_fill + 1'b1;
                end
            end
            ACT_READ: begin
                if (r_rx_pos < r_rx_fill) begin
                    n_read_ok    = 1'b1;
                    n_read_value = r_rx_rd;
                    if (rx_pos_inc == r_rx_fill) begin
                        n_rx_pos  = '0;
                        n_rx_fill = '0;
                    end else begin
                        n_rx_pos = rx_pos_inc;
                    end
                end
            end
        endcase
    end

    // Store writes on commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && tx_we) begin
            r_tx_mem[r_tx_tail] <= r_data;
        end
        if (i_cmd.commit && rx_we) begin
            r_rx_mem[r_rx_fill[RX_AW-1:0]] <= r_data;
        end
    end

    // Pointer and counter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_tx_full <= 1'b0;
            r_drops   <= '0;
            r_rx_pos  <= '0;
            r_rx_fill <= '0;
        end else if (i_cmd.commit) begin
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_tx_full <= n_tx_full;
            r_drops   <= n_drops;
            r_rx_pos  <= n_rx_pos;
            r_rx_fill <= n_rx_fill;
        end
    end

    // Output register, loaded once per item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_emit_valid    <= n_emit_valid;
            o_emit_byte     <= n_emit_byte;
            o_read_ok       <= n_read_ok;
            o_read_value    <= n_read_value;
            o_rx_has_data   <= (n_rx_pos < n_rx_fill);
            o_queue_full    <= n_tx_full;
            o_dropped_count <= n_drops;
        end
    end

    `ASSERT_SAME(a_full_means_equal, i_clk, i_rst_n, r_tx_full, r_tx_head == r_tx_tail)
    `ASSERT_SAME(a_rx_pos_in_fill, i_clk, i_rst_n, 1'b1, r_rx_pos <= r_rx_fill)
    `ASSERT_SAME(a_rx_fill_bound, i_clk, i_rst_n, 1'b1, r_rx_fill <= RX_CW'(RX_DEPTH))

endmodule

### rtl/uart_tx_rx_byte_buffer.sv
// Byte buffer between software and a serial transmitter and receiver.
// Input channel (i_in_valid / o_in_ready) carries one action per item:
// send a byte, transmitter done, byte received, or read a received byte,
// with the data byte and the transmitter line-ready flag.
// Output channel (o_out_valid / i_out_ready) returns exactly one result item
// per input item: the byte handed to the transmitter if any, the byte read
// if any, and the receive-data, ring-full and drop-count status after it.
// An item is captured on acceptance, together with registered reads of the
// ring head and receive slot; it is then committed into the output register,
// and no new item is taken until that commit.
// An item may be accepted while the previous result still waits; its commit
// then holds until the output register is taken, and no further item is
// accepted meanwhile.
// Reset clears the ring pointers, full flag, drop counter and receive
// indices; store contents are not cleared and need no clearing pass.
module uart_tx_rx_byte_buffer
    import utrbb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_line_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_emit_valid,
    output logic [7:0]  o_emit_byte,
    output logic        o_read_ok,
    output logic [7:0]  o_read_value,
    output logic        o_rx_has_data,
    output logic        o_queue_full,
    output logic [15:0] o_dropped_count
);

    t_cmd cmd;

    // Sequencer.
    utrbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Stores, pointers and result register.
    utrbb_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_line_ready    (i_line_ready),
        .o_emit_valid    (o_emit_valid),
        .o_emit_byte     (o_emit_byte),
        .o_read_ok       (o_read_ok),
        .o_read_value    (o_read_value),
        .o_rx_has_data   (o_rx_has_data),
        .o_queue_full    (o_queue_full),
        .o_dropped_count (o_dropped_count)
    );

endmodule

### bench/uart_tx_rx_byte_buffer_tb.sv
module uart_tx_rx_byte_buffer_tb;

    import utrbb_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    // One status item as returned by the block.
    typedef struct packed {
        logic        emit_valid;
        logic [7:0]  emit_byte;
        logic        read_ok;
        logic [7:0]  read_value;
        logic        rx_has_data;
        logic        queue_full;
        logic [15:0] dropped_count;
    } buffer_status_t;

    // Stimulus and handshake signals, all known from time zero.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_action     = ACT_SEND;
    logic [7:0]  i_data_byte  = 8'd0;
    logic        i_line_ready = 1'b0;
    logic        i_out_ready  = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_emit_valid;
    logic [7:0]  o_emit_byte;
    logic        o_read_ok;
    logic [7:0]  o_read_value;
    logic        o_rx_has_data;
    logic        o_queue_full;
    logic [15:0] o_dropped_count;

    // Predicted buffer state.
    logic [7:0]       ring_mem [TX_DEPTH];
    logic [TX_AW-1:0] ring_head;
    logic [TX_AW-1:0] ring_tail;
    logic             ring_full;
    logic [15:0]      drop_cnt;
    logic [7:0]       rx_mem [RX_DEPTH];
    logic [RX_CW-1:0] rx_rd_pos;
    logic [RX_CW-1:0] rx_fill_cnt;

    buffer_status_t predicted_status [$];

    int unsigned error_count   = 0;
    int unsigned result_count  = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    uart_tx_rx_byte_buffer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_line_ready    (i_line_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_emit_valid    (o_emit_valid),
        .o_emit_byte     (o_emit_byte),
        .o_read_ok       (o_read_ok),
        .o_read_value    (o_read_value),
        .o_rx_has_data   (o_rx_has_data),
        .o_queue_full    (o_queue_full),
        .o_dropped_count (o_dropped_count)
    );

    // Free-running clock.
    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver stalls at random, driven away from the sampling edge.
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Advance a transmit ring index with wrap at the ring depth.
    function automatic logic [TX_AW-1:0] ring_advance(input logic [TX_AW-1:0] idx);
        if (idx == TX_AW'(TX_DEPTH - 1)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    // Apply one accepted item to the predicted state and return its status.
    function automatic buffer_status_t step_byte_buffer(input t_action act,
                                                         input logic [7:0] data,
                                                         input logic ready);
        buffer_status_t st;
        st = '0;
        case (act)
            ACT_SEND: begin
                if (ring_full) begin
                    drop_cnt = drop_cnt + 16'd1;
                end else if (ring_tail != ring_head || !ready) begin
                    ring_mem[ring_tail] = data;
                    ring_tail = ring_advance(ring_tail);
                    if (ring_tail == ring_head) begin
                        ring_full = 1'b1;
                    end
                end else begin
                    // Empty ring and free line: the byte bypasses the ring.
                    st.emit_valid = 1'b1;
                    st.emit_byte  = data;
                end
            end
            ACT_TX_DONE: begin
                if (ring_tail != ring_head || ring_full) begin
                    st.emit_valid = 1'b1;
                    st.emit_byte  = ring_mem[ring_head];
                    ring_full     = 1'b0;
                    ring_head     = ring_advance(ring_head);
                end
            end
            ACT_RX_BYTE: begin
                if (rx_fill_cnt < RX_DEPTH) begin
                    rx_mem[rx_fill_cnt[RX_AW-1:0]] = data;
                    rx_fill_cnt = rx_fill_cnt + 1'b1;
                end
            end
            default: begin
                if (rx_rd_pos < rx_fill_cnt) begin
                    st.read_ok    = 1'b1;
                    st.read_value = rx_mem[rx_rd_pos[RX_AW-1:0]];
                    rx_rd_pos     = rx_rd_pos + 1'b1;
                    // Both indices restart once the store has drained.
                    if (rx_rd_pos == rx_fill_cnt) begin
                        rx_rd_pos   = '0;
                        rx_fill_cnt = '0;
                    end
                end
            end
        endcase
        st.rx_has_data   = (rx_rd_pos < rx_fill_cnt);
        st.queue_full    = ring_full;
        st.dropped_count = drop_cnt;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Prediction on each accepted item and checking of each accepted result.
    always @(posedge i_clk) begin
        buffer_status_t got;
        buffer_status_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_emit_valid, o_emit_byte, o_read_ok, o_read_value,
                    o_rx_has_data, o_queue_full, o_dropped_count};
            if (predicted_status.size() == 0) begin
                report_mismatch("result with nothing pending",
                                int'(got.dropped_count), 0);
            end else begin
                want = predicted_status.pop_front();
                if (got.emit_valid != want.emit_valid)
                    report_mismatch("emit_valid", int'(got.emit_valid),
                                    int'(want.emit_valid));
                if (got.emit_byte != want.emit_byte)
                    report_mismatch("emit_byte", int'(got.emit_byte),
                                    int'(want.emit_byte));
                if (got.read_ok != want.read_ok)
                    report_mismatch("read_ok", int'(got.read_ok), int'(want.read_ok));
                if (got.read_value != want.read_value)
                    report_mismatch("read_value", int'(got.read_value),
                                    int'(want.read_value));
                if (got.rx_has_data != want.rx_has_data)
                    report_mismatch("rx_has_data", int'(got.rx_has_data),
                                    int'(want.rx_has_data));
                if (got.queue_full != want.queue_full)
                    report_mismatch("queue_full", int'(got.queue_full),
                                    int'(want.queue_full));
                if (got.dropped_count != want.dropped_count)
                    report_mismatch("dropped_count", int'(got.dropped_count),
                                    int'(want.dropped_count));
            end
            result_count++;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predicted_status.push_back(
                step_byte_buffer(t_action'(i_action), i_data_byte, i_line_ready));
        end
    end

    // Offer one item after a random gap and hold it until it is accepted.
    // Called and returning at a falling edge; valid stays high on return.
    task automatic send_item(input t_action act, input logic [7:0] data,
                             input logic ready);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_action     = act;
        i_data_byte  = data;
        i_line_ready = ready;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result has been taken.
    task automatic wait_results_drained();
        i_in_valid = 1'b0;
        while (predicted_status.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Empty-buffer corner cases, bypass, queuing and receive order.
    task automatic test_directed();
        send_item(ACT_READ,    8'h00, 1'b0);
        send_item(ACT_TX_DONE, 8'hFF, 1'b1);
        send_item(ACT_SEND,    8'h00, 1'b1);
        send_item(ACT_SEND,    8'hFF, 1'b1);
        send_item(ACT_SEND,    8'hFF, 1'b0);
        send_item(ACT_SEND,    8'h00, 1'b1);
        send_item(ACT_SEND,    8'h5A, 1'b0);
        send_item(ACT_TX_DONE, 8'h00, 1'b0);
        send_item(ACT_TX_DONE, 8'hFF, 1'b1);
        send_item(ACT_TX_DONE, 8'h00, 1'b1);
        send_item(ACT_TX_DONE, 8'h00, 1'b1);
        send_item(ACT_RX_BYTE, 8'h00, 1'b0);
        send_item(ACT_RX_BYTE, 8'hFF, 1'b1);
        send_item(ACT_RX_BYTE, 8'hA5, 1'b0);
        send_item(ACT_READ,    8'hFF, 1'b1);
        send_item(ACT_READ,    8'h00, 1'b0);
        send_item(ACT_RX_BYTE, 8'h3C, 1'b1);
        send_item(ACT_READ,    8'h00, 1'b0);
        send_item(ACT_READ,    8'h00, 1'b1);
        // The store has drained here, so a further read finds nothing.
        send_item(ACT_READ,    8'h00, 1'b0);
        send_item(ACT_RX_BYTE, 8'hC3, 1'b0);
        send_item(ACT_READ,    8'h00, 1'b1);
    endtask

    // Fill the transmit ring, overflow it, pause, then drain it past empty.
    task automatic test_tx_overflow();
        for (int i = 0; i < TX_DEPTH + 3; i++) begin
            send_item(ACT_SEND, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        wait_results_drained();
        for (int i = 0; i < TX_DEPTH + 2; i++) begin
            send_item(ACT_TX_DONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // Fill the receive store past full, then read it back past empty.
    task automatic test_rx_overflow();
        for (int i = 0; i < RX_DEPTH + 3; i++) begin
            send_item(ACT_RX_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        for (int i = 0; i < RX_DEPTH + 2; i++) begin
            send_item(ACT_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // Random bursts, each either uniform or leaning toward filling or draining one side.
    task automatic test_random(input int unsigned n_items);
        int unsigned done_items;
        int unsigned burst_len;
        int unsigned mode;
        int unsigned pick;
        t_action     act;
        done_items = 0;
        while (done_items < n_items) begin
            mode      = $urandom_range(4);
            burst_len = $urandom_range(80, 8);
            for (int unsigned i = 0; i < burst_len && done_items < n_items; i++) begin
                pick = $urandom_range(99);
                case (mode)
                    1: act = (pick < 80) ? ACT_SEND : (pick < 90) ? ACT_RX_BYTE :
                             (pick < 95) ? ACT_READ : ACT_TX_DONE;
                    2: act = (pick < 75) ? ACT_TX_DONE : (pick < 85) ? ACT_SEND :
                             (pick < 95) ? ACT_READ : ACT_RX_BYTE;
                    3: act = (pick < 80) ? ACT_RX_BYTE : (pick < 90) ? ACT_SEND :
                             (pick < 95) ? ACT_TX_DONE : ACT_READ;
                    4: act = (pick < 75) ? ACT_READ : (pick < 85) ? ACT_RX_BYTE :
                             (pick < 95) ? ACT_TX_DONE : ACT_SEND;
                    default: act = t_action'($urandom_range(3));
                endcase
                send_item(act, 8'($urandom_range(255)), 1'($urandom_range(1)));
                done_items++;
            end
        end
    endtask

    // Test sequence.
    initial begin
        ring_head   = '0;
        ring_tail   = '0;
        ring_full   = 1'b0;
        drop_cnt    = '0;
        rx_rd_pos   = '0;
        rx_fill_cnt = '0;
        for (int i = 0; i < TX_DEPTH; i++) ring_mem[i] = 8'd0;
        for (int i = 0; i < RX_DEPTH; i++) rx_mem[i] = 8'd0;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 81;
        test_directed();
        test_tx_overflow();
        test_random(155);

        send_idle_pct = 81;
        recv_idle_pct = 12;
        test_rx_overflow();
        test_random(155);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(155);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && predicted_status.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### uart_tx_rx_byte_buffer.f
+incdir+rtl
rtl/utrbb_pkg.sv
rtl/utrbb_ctrl.sv
rtl/utrbb_dpath.sv
rtl/uart_tx_rx_byte_buffer.sv
bench/uart_tx_rx_byte_buffer_tb.sv
